### rtl/core/bgo_pkg.sv
// Shared types and constants of the bitmap glyph overlay core.
package bgo_pkg;

	localparam int ADDR_W      = 22;
	localparam int COLOR_W     = 24;
	localparam int DIM_W       = 12;
	localparam int BPR_W       = 4;
	localparam int ROWS_W      = 7;
	localparam int SLOT_W      = 8;
	localparam int GROW_W      = 6;
	localparam int BIDX_W      = 3;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int CNT_W       = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam int DEF_MAX_WIDTH       = 2048;
	localparam int DEF_MAX_HEIGHT      = 2048;
	localparam int DEF_MAX_GLYPH_BYTES = 8;
	localparam int DEF_MAX_GLYPH_ROWS  = 64;
	localparam int DEF_MAX_CHARS       = 256;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_BPR    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_ROWS   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR     = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR     = 3'd7;

	// Register reset values
	localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 12'd640;
	localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 12'd480;
	localparam logic [BPR_W-1:0]   RST_GLYPH_BPR    = 4'd2;
	localparam logic [ROWS_W-1:0]  RST_GLYPH_ROWS   = 7'd16;
	localparam logic [COLOR_W-1:0] RST_FG_COLOR     = 24'hFFFFFF;
	localparam logic [COLOR_W-1:0] RST_BG_COLOR     = 24'h000000;

	typedef struct packed {
		logic [DIM_W-1:0]   frame_width;
		logic [DIM_W-1:0]   frame_height;
		logic [DIM_W-1:0]   origin_x;
		logic [DIM_W-1:0]   origin_y;
		logic [BPR_W-1:0]   glyph_bytes_per_row;
		logic [ROWS_W-1:0]  glyph_rows;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
	} cfg_t;

	// One run of pixel writes for the back end
	typedef struct packed {
		logic              origin_error;
		logic [ADDR_W-1:0] base_addr;
		logic [CNT_W-1:0]  count;
		logic [7:0]        bits;
	} cmd_t;

endpackage

### rtl/core/bgo_ifs.sv
// Channel interfaces of the bitmap glyph overlay core.
interface bgo_in_if import bgo_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] char_slot;
	logic [GROW_W-1:0] glyph_row;
	logic [BIDX_W-1:0] byte_in_row;
	logic [7:0]        glyph_byte;

	modport source (output valid, char_slot, glyph_row, byte_in_row, glyph_byte,
		input ready);
	modport sink (input valid, char_slot, glyph_row, byte_in_row, glyph_byte,
		output ready);
endinterface

interface bgo_out_if import bgo_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  pixel_address;
	logic [COLOR_W-1:0] pixel_color;
	logic               origin_error;
	logic               last;

	modport source (output valid, pixel_address, pixel_color, origin_error, last,
		input ready);
	modport sink (input valid, pixel_address, pixel_color, origin_error, last,
		output ready);
endinterface

interface bgo_cfg_if import bgo_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/bgo_front.sv
// Front end: accepts glyph bytes, classifies them and builds pixel-run commands.
module bgo_front
	import bgo_pkg::*;
#(
	parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
	parameter int MAX_GLYPH_BYTES = DEF_MAX_GLYPH_BYTES,
	parameter int MAX_GLYPH_ROWS  = DEF_MAX_GLYPH_ROWS,
	parameter int MAX_CHARS       = DEF_MAX_CHARS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	bgo_in_if.sink    glyph,
	output logic      push_valid,
	output cmd_t      push_cmd,
	input  logic      push_ready
);

	localparam int COL_W = 17;
	localparam int YS_W  = DIM_W + 1;

	logic [DIM_W-1:0]  w, h;
	logic [BPR_W-1:0]  bpr;
	logic [ROWS_W-1:0] rows;
	logic              err0, outside0, below0;
	logic [YS_W-1:0]   x0, y0, ysum;
	logic [DIM_W-1:0]  brow0;
	logic [SLOT_W+BPR_W-1:0] slot_off;
	logic [COL_W-1:0]  col0;
	logic              adv1, adv2;

	logic              v_s1, err_s1, keep_s1;
	logic [DIM_W-1:0]  brow_s1;
	logic [COL_W-1:0]  col0_s1;
	logic [7:0]        bits_s1;

	logic              fits;
	logic [COL_W-1:0]  room;
	logic [CNT_W-1:0]  cnt;
	logic [2*DIM_W-1:0] prod;
	logic [ADDR_W-1:0] base;

	logic              v_s2;
	cmd_t              cmd_s2;

	// Saturate the size registers
	assign w    = (32'(cfg.frame_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg.frame_width;
	assign h    = (32'(cfg.frame_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT)
		: cfg.frame_height;
	assign bpr  = (32'(cfg.glyph_bytes_per_row) > MAX_GLYPH_BYTES)
		? BPR_W'(MAX_GLYPH_BYTES) : cfg.glyph_bytes_per_row;
	assign rows = (32'(cfg.glyph_rows) > MAX_GLYPH_ROWS)
		? ROWS_W'(MAX_GLYPH_ROWS) : cfg.glyph_rows;

	// Classify the incoming byte and find its row and first column
	always_comb begin
		err0     = (cfg.frame_width < cfg.origin_x) || (cfg.frame_height < cfg.origin_y);
		outside0 = (ROWS_W'(glyph.glyph_row) >= rows)
			|| (BPR_W'(glyph.byte_in_row) >= bpr)
			|| (32'(glyph.char_slot) >= MAX_CHARS);
		x0       = YS_W'(cfg.origin_x) + YS_W'(cfg.origin_x[0]);
		y0       = YS_W'(cfg.origin_y) + YS_W'(cfg.origin_y[0]);
		ysum     = y0 + YS_W'(glyph.glyph_row);
		below0   = ysum >= YS_W'(h);
		brow0    = DIM_W'(YS_W'(h) - YS_W'(1) - ysum);
		slot_off = glyph.char_slot * bpr;
		col0     = COL_W'(x0) + COL_W'({slot_off, 3'b000})
			+ COL_W'({glyph.byte_in_row, 3'b000});
	end

	// Clip against the frame width and form the base address
	always_comb begin
		fits = col0_s1 < COL_W'(w);
		room = COL_W'(w) - col0_s1;
		cnt  = (room >= COL_W'(8)) ? CNT_W'(8) : CNT_W'(room[CNT_W-1:0]);
		prod = brow_s1 * w;
		base = ADDR_W'(prod + (2*DIM_W)'(col0_s1));
	end

	// Advance when the next stage has room
	assign adv2 = !v_s2 || push_ready;
	assign adv1 = !v_s1 || adv2;
	assign glyph.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= glyph.valid;
			end
			// Drop bytes that produce no pixel
			if (adv2) begin
				v_s2 <= v_s1 && (err_s1 || (keep_s1 && fits));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && glyph.valid) begin
			err_s1  <= err0;
			keep_s1 <= !outside0 && !below0;
			brow_s1 <= brow0;
			col0_s1 <= col0;
			bits_s1 <= glyph.glyph_byte;
		end
		if (adv2 && v_s1) begin
			if (err_s1) begin
				cmd_s2.origin_error <= 1'b1;
				cmd_s2.base_addr    <= '0;
				cmd_s2.count        <= CNT_W'(1);
				cmd_s2.bits         <= '0;
			end else begin
				cmd_s2.origin_error <= 1'b0;
				cmd_s2.base_addr    <= base;
				cmd_s2.count        <= cnt;
				cmd_s2.bits         <= bits_s1;
			end
		end
	end

	assign push_valid = v_s2;
	assign push_cmd   = cmd_s2;

endmodule

### rtl/core/bgo_queue.sv
// Short command queue between the front and back ends.
module bgo_queue
	import bgo_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  cmd_t push_cmd,
	output logic push_ready,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != CNT_QW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

	// Store the command
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/core/bgo_back.sv
// Back end: expands each command into pixel writes, one per cycle while the receiver is ready.
module bgo_back
	import bgo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       pop_valid,
	input  cmd_t       pop_cmd,
	output logic       pop,
	bgo_out_if.source  pixel
);

	logic               act_q;
	cmd_t               cmd_q;
	logic [2:0]         idx_q;
	logic               out_adv, emit, at_end, fin, load;
	logic               pv_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COLOR_W-1:0] color_q;
	logic               err_q, last_q;

	assign out_adv = !pv_q || pixel.ready;
	assign emit    = act_q && out_adv;
	assign at_end  = CNT_W'(idx_q) == (cmd_q.count - CNT_W'(1));
	assign fin     = emit && at_end;
	assign load    = (!act_q || fin) && pop_valid;
	assign pop     = load;

	// Step through the pixels of the current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			pv_q  <= 1'b0;
		end else begin
			if (load) begin
				act_q <= 1'b1;
			end else if (fin) begin
				act_q <= 1'b0;
			end
			if (out_adv) begin
				pv_q <= act_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= pop_cmd;
			idx_q <= '0;
		end else if (emit) begin
			idx_q <= idx_q + 3'd1;
		end
		// Hold the result until the receiver takes it
		if (emit) begin
			addr_q  <= cmd_q.base_addr + ADDR_W'(idx_q);
			err_q   <= cmd_q.origin_error;
			last_q  <= at_end;
			if (cmd_q.origin_error) begin
				color_q <= '0;
			end else begin
				color_q <= cmd_q.bits[~idx_q] ? cfg.fg_color : cfg.bg_color;
			end
		end
	end

	assign pixel.valid         = pv_q;
	assign pixel.pixel_address = addr_q;
	assign pixel.pixel_color   = color_q;
	assign pixel.origin_error  = err_q;
	assign pixel.last          = last_q;

	// An error result stands alone with a zero payload
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.origin_error) |->
		(pixel.last && pixel.pixel_address == '0 && pixel.pixel_color == '0))
		else $error("origin error result not alone or not zero");

	// Pixels of one byte follow back to back at consecutive addresses
	a_next_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready && !pixel.last) |=>
		(pixel.valid && pixel.pixel_address == $past(pixel.pixel_address) + 22'd1))
		else $error("pixel run broken");

	// No command is taken while the current one still has pixels left
	a_no_early_load: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q && !fin) |-> !pop)
		else $error("command loaded over an active one");

endmodule

### rtl/core/bitmap_glyph_overlay_core.sv
// Top level of the bitmap glyph overlay core: registers, front end, queue, back end.
//
// Usage: write the size, origin and color registers on the cfg channel while the
// core is idle (index 0..7: frame width, frame height, origin x, origin y, glyph
// bytes per row, glyph rows, foreground color, background color). Then send glyph
// bytes on the glyph channel, one transaction per byte with its character slot,
// glyph row and byte index. Each byte gives up to eight pixel transactions on the
// pixel channel, leftmost bit first, with last set on the final one; a byte that
// falls wholly outside the frame or glyph gives none, and an origin beyond the
// frame size gives one transaction flagged origin_error.
// When the core is empty, a byte passes the front-end stage registers, the command
// queue, the back end's command register and its output register. The back end
// writes one pixel per cycle while the pixel receiver is ready; the front end takes
// one byte per cycle while glyph.ready is high, and a four-entry command queue
// decouples the two. A skipped byte is dropped after the first front-end stage.
// When the pixel receiver stalls, the output register holds its transaction, the
// queue fills and then glyph.ready drops. Reset clears all valid state and loads
// the register defaults (640 x 480 frame, origin 0, 2 x 16 glyph, white on black).
module bitmap_glyph_overlay_core
	import bgo_pkg::*;
#(
	parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
	parameter int MAX_GLYPH_BYTES = DEF_MAX_GLYPH_BYTES,
	parameter int MAX_GLYPH_ROWS  = DEF_MAX_GLYPH_ROWS,
	parameter int MAX_CHARS       = DEF_MAX_CHARS
) (
	input  logic       clk,
	input  logic       arst_n,
	bgo_cfg_if.sink    cfg,
	bgo_in_if.sink     glyph,
	bgo_out_if.source  pixel
);

	cfg_t cfg_q;
	logic push_valid, push_ready, pop_valid, pop;
	cmd_t push_cmd, pop_cmd;

	assign cfg.ready = 1'b1;

	// Write the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width         <= RST_FRAME_WIDTH;
			cfg_q.frame_height        <= RST_FRAME_HEIGHT;
			cfg_q.origin_x            <= '0;
			cfg_q.origin_y            <= '0;
			cfg_q.glyph_bytes_per_row <= RST_GLYPH_BPR;
			cfg_q.glyph_rows          <= RST_GLYPH_ROWS;
			cfg_q.fg_color            <= RST_FG_COLOR;
			cfg_q.bg_color            <= RST_BG_COLOR;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg.data[DIM_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg.data[DIM_W-1:0];
				REG_ORIGIN_X:     cfg_q.origin_x     <= cfg.data[DIM_W-1:0];
				REG_ORIGIN_Y:     cfg_q.origin_y     <= cfg.data[DIM_W-1:0];
				REG_GLYPH_BPR:    cfg_q.glyph_bytes_per_row <= cfg.data[BPR_W-1:0];
				REG_GLYPH_ROWS:   cfg_q.glyph_rows   <= cfg.data[ROWS_W-1:0];
				REG_FG_COLOR:     cfg_q.fg_color     <= cfg.data[COLOR_W-1:0];
				REG_BG_COLOR:     cfg_q.bg_color     <= cfg.data[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bgo_front #(
		.MAX_WIDTH       (MAX_WIDTH),
		.MAX_HEIGHT      (MAX_HEIGHT),
		.MAX_GLYPH_BYTES (MAX_GLYPH_BYTES),
		.MAX_GLYPH_ROWS  (MAX_GLYPH_ROWS),
		.MAX_CHARS       (MAX_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.glyph      (glyph),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	bgo_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop        (pop)
	);

	bgo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.pixel     (pixel)
	);

endmodule
